// File: rtl/core/rvie_pkg.sv
// Shared types, constants and a helper function for the register machine execute core.
package rvie_pkg;

	localparam int unsigned SLOT_COUNT_DEF = 128;
	localparam int unsigned CODE_DEPTH_DEF = 1024;
	localparam int unsigned DATA_W = 64;
	localparam int unsigned SLOT_FIELD_W = 7;
	localparam int unsigned ADDR_FIELD_W = 10;
	localparam int unsigned REM_W = 17;
	localparam int unsigned REC_SH = 2 * ADDR_FIELD_W;

	typedef enum logic [2:0] {
		MODE_SET     = 3'd0,
		MODE_ADD     = 3'd1,
		MODE_PRINT   = 3'd2,
		MODE_GE      = 3'd3,
		MODE_JUMP_IF = 3'd4,
		MODE_JUMP    = 3'd5
	} mode_t;

	typedef struct packed {
		logic [2:0]                mode;
		logic [SLOT_FIELD_W-1:0]   first_slot;
		logic [SLOT_FIELD_W-1:0]   second_slot;
		logic [SLOT_FIELD_W-1:0]   dest_slot;
		logic signed [DATA_W-1:0]  immediate;
		logic [ADDR_FIELD_W-1:0]   jump_target;
	} instr_t;

	typedef struct packed {
		logic [ADDR_FIELD_W-1:0]   next_address;
		logic                      print_valid;
		logic signed [DATA_W-1:0]  print_value;
	} result_t;

	typedef struct packed {
		logic wr_en;
		logic print_valid;
	} alu_ctl_t;

	// Remainder of a narrow field by an elaboration-time constant. The quotient comes
	// from a multiplication by the rounded-up reciprocal of the divisor scaled by
	// 2^REC_SH, which is exact for every value that the field can hold. A divisor
	// above the field range leaves the field as it is.
	function automatic logic [ADDR_FIELD_W-1:0] rem_const(input logic [ADDR_FIELD_W-1:0] raw,
		input logic [REM_W-1:0] divisor, input logic [REC_SH-1:0] recip);
		logic [ADDR_FIELD_W+REC_SH-1:0] prod;
		logic [ADDR_FIELD_W-1:0]        quo;
		logic [ADDR_FIELD_W+REM_W-1:0]  back;
		prod = {{REC_SH{1'b0}}, raw} * {{ADDR_FIELD_W{1'b0}}, recip};
		quo  = prod[ADDR_FIELD_W+REC_SH-1:REC_SH];
		back = {{REM_W{1'b0}}, quo} * {{ADDR_FIELD_W{1'b0}}, divisor};
		if (divisor >= REM_W'(1 << ADDR_FIELD_W)) begin
			return raw;
		end
		return raw - back[ADDR_FIELD_W-1:0];
	endfunction

endpackage

// File: rtl/core/rvie_slot_mem.sv
// Slot file memory: one write port, two registered read ports, per-slot valid bits.
module rvie_slot_mem #(
	parameter int unsigned SLOT_COUNT = rvie_pkg::SLOT_COUNT_DEF,
	parameter int unsigned SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rd_en,
	input  logic [SW-1:0]                rd_addr_a,
	input  logic [SW-1:0]                rd_addr_b,
	output logic [rvie_pkg::DATA_W-1:0]  rd_data_a,
	output logic [rvie_pkg::DATA_W-1:0]  rd_data_b,
	input  logic                         wr_en,
	input  logic [SW-1:0]                wr_addr,
	input  logic [rvie_pkg::DATA_W-1:0]  wr_data
);

	logic [rvie_pkg::DATA_W-1:0] mem [SLOT_COUNT];
	logic [SLOT_COUNT-1:0]       slot_vld_q;
	logic [rvie_pkg::DATA_W-1:0] rd_a_q;
	logic [rvie_pkg::DATA_W-1:0] rd_b_q;
	logic                        rd_vld_a_q;
	logic                        rd_vld_b_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_a_q <= mem[rd_addr_a];
			rd_b_q <= mem[rd_addr_b];
		end
	end

	// A slot that was never written since reset reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_vld_q <= '0;
			rd_vld_a_q <= 1'b0;
			rd_vld_b_q <= 1'b0;
		end else begin
			if (wr_en) begin
				slot_vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_a_q <= slot_vld_q[rd_addr_a];
				rd_vld_b_q <= slot_vld_q[rd_addr_b];
			end
		end
	end

	assign rd_data_a = rd_vld_a_q ? rd_a_q : '0;
	assign rd_data_b = rd_vld_b_q ? rd_b_q : '0;

endmodule

// File: rtl/core/rvie_alu.sv
// Execute logic: slot arithmetic, compare, print selection and next address.
module rvie_alu #(
	parameter int unsigned CODE_DEPTH = rvie_pkg::CODE_DEPTH_DEF,
	parameter int unsigned AW = $clog2(CODE_DEPTH)
) (
	input  logic [2:0]                          mode,
	input  logic [rvie_pkg::DATA_W-1:0]         opa,
	input  logic [rvie_pkg::DATA_W-1:0]         opb,
	input  logic [rvie_pkg::DATA_W-1:0]         imm,
	input  logic [AW-1:0]                       target,
	input  logic [AW-1:0]                       cur_addr,
	output rvie_pkg::alu_ctl_t                  ctl,
	output logic [rvie_pkg::DATA_W-1:0]         wr_data,
	output logic [rvie_pkg::DATA_W-1:0]         print_value,
	output logic [AW-1:0]                       next_addr
);

	logic [AW:0]   inc;
	logic [AW-1:0] seq_addr;

	assign inc      = {1'b0, cur_addr} + {{AW{1'b0}}, 1'b1};
	assign seq_addr = (inc == (AW+1)'(CODE_DEPTH)) ? '0 : inc[AW-1:0];

	always_comb begin
		ctl         = '0;
		wr_data     = '0;
		print_value = '0;
		next_addr   = seq_addr;
		case (mode)
			rvie_pkg::MODE_SET: begin
				ctl.wr_en = 1'b1;
				wr_data   = imm;
			end
			rvie_pkg::MODE_ADD: begin
				ctl.wr_en = 1'b1;
				wr_data   = opa + opb;
			end
			rvie_pkg::MODE_PRINT: begin
				ctl.print_valid = 1'b1;
				print_value     = opa;
			end
			rvie_pkg::MODE_GE: begin
				ctl.wr_en = 1'b1;
				wr_data   = {{(rvie_pkg::DATA_W-1){1'b0}}, ($signed(opa) >= $signed(opb))};
			end
			rvie_pkg::MODE_JUMP_IF: begin
				if (opa != '0) begin
					next_addr = target;
				end
			end
			rvie_pkg::MODE_JUMP: begin
				next_addr = target;
			end
			default: begin
			end
		endcase
	end

endmodule

// File: rtl/core/register_vm_instruction_execute_core.sv
// Pipeline: an accepted instruction beat goes through the execute stage and the result
// register. Throughput: one instruction per cycle while the result is not stalled; the
// slot file read at accept, its write-back and a back-to-back dependence bypass set it.
// Reset: the pipeline and result register empty, every slot reads as zero (per-slot valid
// bits clear at once, no clearing pass), and the instruction address is zero.
module register_vm_instruction_execute_core #(
	parameter int unsigned SLOT_COUNT = rvie_pkg::SLOT_COUNT_DEF,
	parameter int unsigned CODE_DEPTH = rvie_pkg::CODE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              instr_valid,
	output logic              instr_stall,
	input  rvie_pkg::instr_t  instr,
	output logic              result_valid,
	input  logic              result_stall,
	output rvie_pkg::result_t result
);

	localparam int unsigned SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int unsigned AW = $clog2(CODE_DEPTH);
	localparam int unsigned DW = rvie_pkg::DATA_W;
	localparam int unsigned FW = rvie_pkg::ADDR_FIELD_W;
	localparam int unsigned SLOT_RECIP = ((1 << rvie_pkg::REC_SH) + SLOT_COUNT - 1) / SLOT_COUNT;
	localparam int unsigned ADDR_RECIP = ((1 << rvie_pkg::REC_SH) + CODE_DEPTH - 1) / CODE_DEPTH;

	logic              instr_acc;
	logic              s1_fire;
	logic [SW-1:0]     a_idx;
	logic [SW-1:0]     b_idx;
	logic [SW-1:0]     d_idx;
	logic [AW-1:0]     target_idx;
	logic [FW-1:0]     a_rem;
	logic [FW-1:0]     b_rem;
	logic [FW-1:0]     d_rem;
	logic [FW-1:0]     t_rem;

	logic              vld_s1;
	logic [2:0]        mode_s1;
	logic [SW-1:0]     d_s1;
	logic [DW-1:0]     imm_s1;
	logic [AW-1:0]     target_s1;
	logic              fwd_a_s1;
	logic              fwd_b_s1;
	logic [DW-1:0]     fwd_val_s1;
	logic [AW-1:0]     cur_addr_q;

	logic [DW-1:0]     rd_a;
	logic [DW-1:0]     rd_b;
	logic [DW-1:0]     opa;
	logic [DW-1:0]     opb;
	rvie_pkg::alu_ctl_t alu_ctl;
	logic [DW-1:0]     alu_wr_data;
	logic [DW-1:0]     alu_print_value;
	logic [AW-1:0]     alu_next;
	logic [AW+FW-1:0]  next_ext;
	logic              mem_wr_en;

	logic              result_valid_q;
	rvie_pkg::result_t result_q;

	assign a_rem = rvie_pkg::rem_const({{(FW-rvie_pkg::SLOT_FIELD_W){1'b0}}, instr.first_slot},
		rvie_pkg::REM_W'(SLOT_COUNT), rvie_pkg::REC_SH'(SLOT_RECIP));
	assign b_rem = rvie_pkg::rem_const({{(FW-rvie_pkg::SLOT_FIELD_W){1'b0}}, instr.second_slot},
		rvie_pkg::REM_W'(SLOT_COUNT), rvie_pkg::REC_SH'(SLOT_RECIP));
	assign d_rem = rvie_pkg::rem_const({{(FW-rvie_pkg::SLOT_FIELD_W){1'b0}}, instr.dest_slot},
		rvie_pkg::REM_W'(SLOT_COUNT), rvie_pkg::REC_SH'(SLOT_RECIP));
	assign t_rem = rvie_pkg::rem_const(instr.jump_target, rvie_pkg::REM_W'(CODE_DEPTH),
		rvie_pkg::REC_SH'(ADDR_RECIP));

	assign a_idx      = SW'(a_rem);
	assign b_idx      = SW'(b_rem);
	assign d_idx      = SW'(d_rem);
	assign target_idx = AW'(t_rem);

	assign s1_fire     = vld_s1 && (!result_valid_q || !result_stall);
	assign instr_stall = vld_s1 && !s1_fire;
	assign instr_acc   = instr_valid && !instr_stall;
	assign mem_wr_en   = s1_fire && alu_ctl.wr_en;

	rvie_slot_mem #(
		.SLOT_COUNT (SLOT_COUNT),
		.SW         (SW)
	) u_slot_mem (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (instr_acc),
		.rd_addr_a (a_idx),
		.rd_addr_b (b_idx),
		.rd_data_a (rd_a),
		.rd_data_b (rd_b),
		.wr_en     (mem_wr_en),
		.wr_addr   (d_s1),
		.wr_data   (alu_wr_data)
	);

	// The memory returns the old value when the slot is written at the read edge,
	// so that case takes the bypass register instead.
	assign opa = fwd_a_s1 ? fwd_val_s1 : rd_a;
	assign opb = fwd_b_s1 ? fwd_val_s1 : rd_b;

	rvie_alu #(
		.CODE_DEPTH (CODE_DEPTH),
		.AW         (AW)
	) u_alu (
		.mode        (mode_s1),
		.opa         (opa),
		.opb         (opb),
		.imm         (imm_s1),
		.target      (target_s1),
		.cur_addr    (cur_addr_q),
		.ctl         (alu_ctl),
		.wr_data     (alu_wr_data),
		.print_value (alu_print_value),
		.next_addr   (alu_next)
	);

	assign next_ext = {{FW{1'b0}}, alu_next};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1         <= 1'b0;
			fwd_a_s1       <= 1'b0;
			fwd_b_s1       <= 1'b0;
			cur_addr_q     <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (instr_acc) begin
				vld_s1   <= 1'b1;
				fwd_a_s1 <= mem_wr_en && (d_s1 == a_idx);
				fwd_b_s1 <= mem_wr_en && (d_s1 == b_idx);
			end else if (s1_fire) begin
				vld_s1 <= 1'b0;
			end
			if (s1_fire) begin
				cur_addr_q     <= alu_next;
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (instr_acc) begin
			mode_s1    <= instr.mode;
			d_s1       <= d_idx;
			imm_s1     <= instr.immediate;
			target_s1  <= target_idx;
			fwd_val_s1 <= alu_wr_data;
		end
		if (s1_fire) begin
			result_q.next_address <= next_ext[FW-1:0];
			result_q.print_valid  <= alu_ctl.print_valid;
			result_q.print_value  <= alu_print_value;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_stall_needs_occupied_stage: assert property (@(posedge clk) disable iff (!arst_n)
		instr_stall |-> vld_s1)
		else $error("instruction stall raised with an empty execute stage");

	a_fire_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire |=> result_valid)
		else $error("executed instruction did not produce a result beat");

	a_quiet_print_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.print_valid) |-> (result.print_value == '0))
		else $error("print value nonzero on a result beat without a print");

	a_write_only_on_fire: assert property (@(posedge clk) disable iff (!arst_n)
		mem_wr_en |-> (vld_s1 && !instr_stall))
		else $error("slot file written by a stalled or empty stage");

endmodule
